[src/wcvm_pkg.sv]
// Shared package for the wall-corners-to-view-matrix block.
// Widths, constants, carried record types and helper functions.
// No dependencies.
package wcvm_pkg;

  // Coordinate format: signed Q16.16
  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int OUT_W      = 32;

  // Edge vectors and corner sums need one bit more than a coordinate
  localparam int EDGE_W      = COORD_BITS + 1;
  localparam int EDGE_LEN_W  = EDGE_W + 1;
  // Unit components lie in [-1.0, 1.0] in Q.F
  localparam int UNIT_W      = FRAC_BITS + 2;
  // Cross product of two unit vectors, kept in Q.2F
  localparam int CROSS_W     = 2 * FRAC_BITS + 2;
  localparam int CROSS_LEN_W = CROSS_W + 1;
  // Translation dot products
  localparam int PROD_W      = UNIT_W + EDGE_W;
  localparam int DOT_W       = PROD_W + 2;
  localparam int TR_W        = DOT_W + 2;

  localparam int GRP_W = 2;
  localparam logic [GRP_W-1:0] GRP_XLATE = 2'd3;

  localparam logic [OUT_W-1:0] ONE_Q   = OUT_W'(1) << FRAC_BITS;
  localparam logic [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // Record carried alongside the normal through its normalizer
  typedef struct packed {
    logic [2:0][UNIT_W-1:0]     uh;
    logic [2:0][UNIT_W-1:0]     vh;
    logic [EDGE_LEN_W-1:0]      ulen;
    logic [EDGE_LEN_W-1:0]      vlen;
    logic [2:0][EDGE_W-1:0]     csum;
  } wcvm_wside_t;

  // Finished matrix, ready to go out as four groups
  typedef struct packed {
    logic [2:0][UNIT_W-1:0] uh;
    logic [2:0][UNIT_W-1:0] vh;
    logic [2:0][UNIT_W-1:0] wh;
    logic [2:0][OUT_W-1:0]  tr;
    logic [OUT_W-1:0]       width;
    logic [OUT_W-1:0]       height;
    logic                   degen;
  } wcvm_mat_t;

  // Sign-extend a unit component to an output entry
  function automatic logic [OUT_W-1:0] sext_unit(input logic [UNIT_W-1:0] x);
    return {{(OUT_W-UNIT_W){x[UNIT_W-1]}}, x};
  endfunction

  // Clamp an unsigned length to the output range
  function automatic logic [OUT_W-1:0] sat_len(input logic [EDGE_LEN_W-1:0] x);
    return (|x[EDGE_LEN_W-1:OUT_W]) ? {OUT_W{1'b1}} : x[OUT_W-1:0];
  endfunction

endpackage

[src/wcvm_in_if.sv]
// Input channel: three wall corners per item, valid/ready handshake.
// Depends on wcvm_pkg.
interface wcvm_in_if;
  import wcvm_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] bottom_left_x;
  logic signed [COORD_BITS-1:0] bottom_left_y;
  logic signed [COORD_BITS-1:0] bottom_left_z;
  logic signed [COORD_BITS-1:0] bottom_right_x;
  logic signed [COORD_BITS-1:0] bottom_right_y;
  logic signed [COORD_BITS-1:0] bottom_right_z;
  logic signed [COORD_BITS-1:0] top_left_x;
  logic signed [COORD_BITS-1:0] top_left_y;
  logic signed [COORD_BITS-1:0] top_left_z;

  modport source (
    output valid, bottom_left_x, bottom_left_y, bottom_left_z,
    output bottom_right_x, bottom_right_y, bottom_right_z,
    output top_left_x, top_left_y, top_left_z,
    input  ready
  );

  modport sink (
    input  valid, bottom_left_x, bottom_left_y, bottom_left_z,
    input  bottom_right_x, bottom_right_y, bottom_right_z,
    input  top_left_x, top_left_y, top_left_z,
    output ready
  );
endinterface

[src/wcvm_out_if.sv]
// Output channel: one matrix column group per item, valid/ready handshake.
// Depends on wcvm_pkg.
interface wcvm_out_if;
  import wcvm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [GRP_W-1:0]        group_index;
  logic signed [OUT_W-1:0] elem_first;
  logic signed [OUT_W-1:0] elem_second;
  logic signed [OUT_W-1:0] elem_third;
  logic signed [OUT_W-1:0] elem_fourth;
  logic [OUT_W-1:0]        wall_width;
  logic [OUT_W-1:0]        wall_height;
  logic                    degenerate;
  logic                    last_group;

  modport source (
    output valid, group_index, elem_first, elem_second, elem_third, elem_fourth,
    output wall_width, wall_height, degenerate, last_group,
    input  ready
  );

  modport sink (
    input  valid, group_index, elem_first, elem_second, elem_third, elem_fourth,
    input  wall_width, wall_height, degenerate, last_group,
    output ready
  );
endinterface

[src/wcvm_norm.sv]
// Pipelined 3-vector normalizer: sum of squares, one root bit per stage,
// one quotient bit per stage for all three components. Depends on wcvm_pkg.
module wcvm_norm #(
  parameter int VEC_W  = 33,
  parameter int SIDE_W = 1
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [2:0][VEC_W-1:0]               vec,
  input  logic [SIDE_W-1:0]                   side_in,
  output logic                                out_valid,
  output logic [2:0][wcvm_pkg::UNIT_W-1:0]    unit_vec,
  output logic [VEC_W:0]                      len,
  output logic [SIDE_W-1:0]                   side_out
);
  import wcvm_pkg::*;

  localparam int ROOT_W = VEC_W + 1;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 2;
  localparam int DR_W   = ROOT_W + 1;
  localparam int QB     = UNIT_W;
  localparam int NS     = ROOT_W;
  localparam int ND     = QB;

  // Magnitude stage
  logic                  a_vld;
  logic [2:0][VEC_W-1:0] a_mag;
  logic [2:0]            a_neg;
  logic [SIDE_W-1:0]     a_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a_neg[i] <= vec[i][VEC_W-1];
        a_mag[i] <= vec[i][VEC_W-1] ? (~vec[i] + 1'b1) : vec[i];
      end
      a_side <= side_in;
    end
  end

  // Square stage
  logic                    b_vld;
  logic [2:0][2*VEC_W-1:0] b_sq;
  logic [2:0][VEC_W-1:0]   b_mag;
  logic [2:0]              b_neg;
  logic [SIDE_W-1:0]       b_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (en) begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        b_sq[i] <= a_mag[i] * a_mag[i];
      end
      b_mag  <= a_mag;
      b_neg  <= a_neg;
      b_side <= a_side;
    end
  end

  // Square root pipeline, index 0 holds the radicand
  logic                  s_vld  [NS+1];
  logic [REM_W-1:0]      s_rem  [NS+1];
  logic [ROOT_W-1:0]     s_root [NS+1];
  logic [RAD_W-1:0]      s_rad  [NS+1];
  logic [2:0][VEC_W-1:0] s_mag  [NS+1];
  logic [2:0]            s_neg  [NS+1];
  logic [SIDE_W-1:0]     s_side [NS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      s_vld[0] <= 1'b0;
    end else if (en) begin
      s_vld[0] <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_rad[0]  <= RAD_W'(b_sq[0]) + RAD_W'(b_sq[1]) + RAD_W'(b_sq[2]);
      s_rem[0]  <= '0;
      s_root[0] <= '0;
      s_mag[0]  <= b_mag;
      s_neg[0]  <= b_neg;
      s_side[0] <= b_side;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             ge;

    // Bring down two radicand bits and try the next root bit
    assign rem_sh = {s_rem[k][REM_W-3:0], s_rad[k][RAD_W-1 -: 2]};
    assign trial  = {s_root[k], 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        s_vld[k+1] <= 1'b0;
      end else if (en) begin
        s_vld[k+1] <= s_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_rem[k+1]  <= ge ? (rem_sh - trial) : rem_sh;
        s_root[k+1] <= {s_root[k][ROOT_W-2:0], ge};
        s_rad[k+1]  <= {s_rad[k][RAD_W-3:0], 2'b00};
        s_mag[k+1]  <= s_mag[k];
        s_neg[k+1]  <= s_neg[k];
        s_side[k+1] <= s_side[k];
      end
    end
  end

  // Division pipeline, one quotient bit per stage
  logic                  d_vld  [1:ND];
  logic [2:0][DR_W-1:0]  d_r    [1:ND];
  logic [2:0][QB-1:0]    d_q    [1:ND];
  logic [ROOT_W-1:0]     d_len  [1:ND];
  logic [2:0]            d_neg  [1:ND];
  logic [SIDE_W-1:0]     d_side [1:ND];

  for (genvar j = 0; j < ND; j++) begin : g_div
    logic                 vld_in;
    logic [2:0][DR_W-1:0] r_in;
    logic [2:0][QB-1:0]   q_in;
    logic [ROOT_W-1:0]    len_in;
    logic [2:0]           neg_in;
    logic [SIDE_W-1:0]    side_src;
    logic [2:0][DR_W-1:0] rs;
    logic [2:0]           ge;

    if (j == 0) begin : g_first
      assign vld_in   = s_vld[NS];
      assign len_in   = s_root[NS];
      assign neg_in   = s_neg[NS];
      assign side_src = s_side[NS];
      assign q_in     = '0;
      for (genvar i = 0; i < 3; i++) begin : g_ld
        assign r_in[i] = DR_W'(s_mag[NS][i]);
      end
      // First step compares the magnitude as it stands
      assign rs = r_in;
    end else begin : g_next
      assign vld_in   = d_vld[j];
      assign len_in   = d_len[j];
      assign neg_in   = d_neg[j];
      assign side_src = d_side[j];
      assign q_in     = d_q[j];
      assign r_in     = d_r[j];
      for (genvar i = 0; i < 3; i++) begin : g_sh
        assign rs[i] = {r_in[i][DR_W-2:0], 1'b0};
      end
    end

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        ge[i] = rs[i] >= DR_W'(len_in);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        d_vld[j+1] <= 1'b0;
      end else if (en) begin
        d_vld[j+1] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          d_r[j+1][i] <= ge[i] ? (rs[i] - DR_W'(len_in)) : rs[i];
          d_q[j+1][i] <= {q_in[i][QB-2:0], ge[i]};
        end
        d_len[j+1]  <= len_in;
        d_neg[j+1]  <= neg_in;
        d_side[j+1] <= side_src;
      end
    end
  end

  // Round half away from zero, restore sign, zero out a null vector
  logic [2:0][QB:0]   q_sum;
  logic [2:0][QB-1:0] q_rnd;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q_sum[i] = {1'b0, d_q[ND][i]} + 1'b1;
      q_rnd[i] = q_sum[i][QB:1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d_vld[ND];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (d_len[ND] == '0) begin
          unit_vec[i] <= '0;
        end else if (d_neg[ND][i]) begin
          unit_vec[i] <= ~q_rnd[i] + 1'b1;
        end else begin
          unit_vec[i] <= q_rnd[i];
        end
      end
      len      <= d_len[ND];
      side_out <= d_side[ND];
    end
  end

endmodule

[src/wcvm_xlate.sv]
// Translation column: dot products of the axes with the corner sum,
// rounding and saturation, plus lengths and degenerate flag. Depends on wcvm_pkg.
module wcvm_xlate (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  wcvm_pkg::wcvm_wside_t                  side,
  input  logic [2:0][wcvm_pkg::UNIT_W-1:0]       wh,
  input  logic [wcvm_pkg::CROSS_LEN_W-1:0]       wlen,
  output logic                                   out_valid,
  output wcvm_pkg::wcvm_mat_t                    mat
);
  import wcvm_pkg::*;

  logic [2:0][2:0][UNIT_W-1:0] ax;

  assign ax[0] = side.uh;
  assign ax[1] = side.vh;
  assign ax[2] = wh;

  // Product stage
  logic                        p_vld;
  logic [2:0][2:0][PROD_W-1:0] p_prod;
  wcvm_mat_t                   p_mat;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else if (en) begin
      p_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          p_prod[k][i] <= $signed(ax[k][i]) * $signed(side.csum[i]);
        end
      end
      p_mat.uh     <= side.uh;
      p_mat.vh     <= side.vh;
      p_mat.wh     <= wh;
      p_mat.tr     <= '0;
      p_mat.width  <= sat_len(side.ulen);
      p_mat.height <= sat_len(side.vlen);
      p_mat.degen  <= (side.ulen == '0) || (side.vlen == '0) || (wlen == '0);
    end
  end

  // Sum stage
  logic                       s_vld;
  logic signed [DOT_W-1:0]    s_dot [3];
  wcvm_mat_t                  s_mat;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_vld <= 1'b0;
    end else if (en) begin
      s_vld <= p_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s_dot[k] <= DOT_W'($signed(p_prod[k][0])) + DOT_W'($signed(p_prod[k][1]))
                  + DOT_W'($signed(p_prod[k][2]));
      end
      s_mat <= p_mat;
    end
  end

  // Negate, halve with rounding to nearest (ties toward plus infinity), saturate
  logic signed [TR_W-1:0] t_val [3];
  logic signed [TR_W-1:0] t_sh  [3];
  logic [2:0][OUT_W-1:0]  t_sat;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      t_val[k] = (TR_W'(1) <<< FRAC_BITS) - TR_W'(s_dot[k]);
      t_sh[k]  = t_val[k] >>> (FRAC_BITS + 1);
      if ((&t_sh[k][TR_W-1:OUT_W-1]) || !(|t_sh[k][TR_W-1:OUT_W-1])) begin
        t_sat[k] = t_sh[k][OUT_W-1:0];
      end else if (t_sh[k][TR_W-1]) begin
        t_sat[k] = SAT_MIN;
      end else begin
        t_sat[k] = SAT_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s_vld;
    end
  end

  // Advance the matrix, with the saturated translation in place
  always_ff @(posedge clk) begin
    if (en) begin
      mat.uh     <= s_mat.uh;
      mat.vh     <= s_mat.vh;
      mat.wh     <= s_mat.wh;
      mat.tr     <= t_sat;
      mat.width  <= s_mat.width;
      mat.height <= s_mat.height;
      mat.degen  <= s_mat.degen;
    end
  end

endmodule

[src/wall_corners_to_view_matrix.sv]
// Top level: wall corners in, 4x4 column-major view matrix out as four groups.
// Depends on wcvm_pkg, wcvm_in_if, wcvm_out_if, wcvm_norm, wcvm_xlate.
//
//  port    | dir | item                                  | per item
//  --------+-----+---------------------------------------+---------------
//  wall    | in  | BL, BR, TL corners, signed Q16.16     | one wall
//  matrix  | out | column group, width, height, flags    | four groups
//
// The two normalizers in series, of one root bit and one quotient bit per
// stage, make up most of the pipeline depth. A wall yields four groups,
// one per cycle while the output is ready, and the pipeline keeps taking
// new walls while they go out. The pipeline stalls as a whole only when its
// last stage is full and the output register still holds groups.
// Reset clears valid bits and the group counter; data registers keep junk.
module wall_corners_to_view_matrix (
  input  logic          clk,
  input  logic          rst,
  wcvm_in_if.sink       wall,
  wcvm_out_if.source    matrix
);
  import wcvm_pkg::*;

  logic      en;
  logic      x_vld;
  wcvm_mat_t x_mat;
  logic      hold_vld;
  wcvm_mat_t hold;
  logic [GRP_W-1:0] grp;
  logic      done;

  // Input stage: edges and corner sums
  logic                   i_vld;
  logic [2:0][EDGE_W-1:0] i_u;
  logic [2:0][EDGE_W-1:0] i_v;
  logic [2:0][EDGE_W-1:0] i_c;

  assign wall.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      i_vld <= 1'b0;
    end else if (en) begin
      i_vld <= wall.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      i_u[0] <= EDGE_W'(wall.bottom_right_x) - EDGE_W'(wall.bottom_left_x);
      i_u[1] <= EDGE_W'(wall.bottom_right_y) - EDGE_W'(wall.bottom_left_y);
      i_u[2] <= EDGE_W'(wall.bottom_right_z) - EDGE_W'(wall.bottom_left_z);
      i_v[0] <= EDGE_W'(wall.top_left_x) - EDGE_W'(wall.bottom_left_x);
      i_v[1] <= EDGE_W'(wall.top_left_y) - EDGE_W'(wall.bottom_left_y);
      i_v[2] <= EDGE_W'(wall.top_left_z) - EDGE_W'(wall.bottom_left_z);
      i_c[0] <= EDGE_W'(wall.bottom_right_x) + EDGE_W'(wall.top_left_x);
      i_c[1] <= EDGE_W'(wall.bottom_right_y) + EDGE_W'(wall.top_left_y);
      i_c[2] <= EDGE_W'(wall.bottom_right_z) + EDGE_W'(wall.top_left_z);
    end
  end

  // Normalize both edges side by side; the corner sums ride along split
  logic                       u_vld;
  logic [2:0][UNIT_W-1:0]     u_unit;
  logic [EDGE_LEN_W-1:0]      u_len;
  logic [2*EDGE_W-1:0]        u_side;
  logic                       v_vld;
  logic [2:0][UNIT_W-1:0]     v_unit;
  logic [EDGE_LEN_W-1:0]      v_len;
  logic [EDGE_W-1:0]          v_side;

  wcvm_norm #(.VEC_W(EDGE_W), .SIDE_W(2*EDGE_W)) u_norm_u (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(i_vld), .vec(i_u), .side_in({i_c[1], i_c[0]}),
    .out_valid(u_vld), .unit_vec(u_unit), .len(u_len), .side_out(u_side)
  );

  wcvm_norm #(.VEC_W(EDGE_W), .SIDE_W(EDGE_W)) u_norm_v (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(i_vld), .vec(i_v), .side_in(i_c[2]),
    .out_valid(v_vld), .unit_vec(v_unit), .len(v_len), .side_out(v_side)
  );

  // Cross product: products first, then differences
  logic                       x1_vld;
  logic [5:0][2*UNIT_W-1:0]   x1_p;
  wcvm_wside_t                x1_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      x1_vld <= 1'b0;
    end else if (en) begin
      x1_vld <= u_vld && v_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_p[0] <= $signed(u_unit[1]) * $signed(v_unit[2]);
      x1_p[1] <= $signed(u_unit[2]) * $signed(v_unit[1]);
      x1_p[2] <= $signed(u_unit[2]) * $signed(v_unit[0]);
      x1_p[3] <= $signed(u_unit[0]) * $signed(v_unit[2]);
      x1_p[4] <= $signed(u_unit[0]) * $signed(v_unit[1]);
      x1_p[5] <= $signed(u_unit[1]) * $signed(v_unit[0]);
      x1_side.uh   <= u_unit;
      x1_side.vh   <= v_unit;
      x1_side.ulen <= u_len;
      x1_side.vlen <= v_len;
      x1_side.csum <= {v_side, u_side};
    end
  end

  logic                        x2_vld;
  logic [2:0][CROSS_W-1:0]     x2_wc;
  wcvm_wside_t                 x2_side;
  logic signed [2*UNIT_W:0]    x_diff [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      x_diff[k] = $signed(x1_p[2*k]) - $signed(x1_p[2*k+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x2_vld <= 1'b0;
    end else if (en) begin
      x2_vld <= x1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        x2_wc[k] <= x_diff[k][CROSS_W-1:0];
      end
      x2_side <= x1_side;
    end
  end

  // Normalize the wall normal
  logic                        w_vld;
  logic [2:0][UNIT_W-1:0]      w_unit;
  logic [CROSS_LEN_W-1:0]      w_len;
  wcvm_wside_t                 w_side;

  wcvm_norm #(.VEC_W(CROSS_W), .SIDE_W($bits(wcvm_wside_t))) u_norm_w (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(x2_vld), .vec(x2_wc), .side_in(x2_side),
    .out_valid(w_vld), .unit_vec(w_unit), .len(w_len), .side_out(w_side)
  );

  wcvm_xlate u_xlate (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(w_vld), .side(w_side), .wh(w_unit), .wlen(w_len),
    .out_valid(x_vld), .mat(x_mat)
  );

  // Output register: hold one matrix, send its four groups in order
  assign done = hold_vld && matrix.ready && (grp == GRP_XLATE);
  assign en   = !x_vld || !hold_vld || done;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_vld <= 1'b0;
      grp      <= '0;
    end else if (en && x_vld) begin
      hold_vld <= 1'b1;
      grp      <= '0;
    end else if (done) begin
      hold_vld <= 1'b0;
      grp      <= '0;
    end else if (hold_vld && matrix.ready) begin
      grp <= grp + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en && x_vld) begin
      hold <= x_mat;
    end
  end

  // Select the current group
  always_comb begin
    matrix.valid       = hold_vld;
    matrix.group_index = grp;
    matrix.wall_width  = hold.width;
    matrix.wall_height = hold.height;
    matrix.degenerate  = hold.degen;
    matrix.last_group  = grp == GRP_XLATE;
    if (grp == GRP_XLATE) begin
      matrix.elem_first  = hold.tr[0];
      matrix.elem_second = hold.tr[1];
      matrix.elem_third  = hold.tr[2];
      matrix.elem_fourth = ONE_Q;
    end else begin
      matrix.elem_first  = sext_unit(hold.uh[grp]);
      matrix.elem_second = sext_unit(hold.vh[grp]);
      matrix.elem_third  = sext_unit(hold.wh[grp]);
      matrix.elem_fourth = '0;
    end
  end

endmodule

[src/wcvm_checker.sv]
// Port-level checks on the matrix output channel, bound to the top level.
// Depends on wcvm_pkg and wall_corners_to_view_matrix.
module wcvm_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [wcvm_pkg::GRP_W-1:0]     group_index,
  input logic [wcvm_pkg::OUT_W-1:0]     elem_fourth,
  input logic [wcvm_pkg::OUT_W-1:0]     wall_width,
  input logic                           degenerate,
  input logic                           last_group
);
  import wcvm_pkg::*;

  // A stalled group stays on the port
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(group_index))
    else $error("stalled group changed");

  // Groups of one matrix follow each other in order
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && (group_index != GRP_XLATE)
    |=> out_valid && (group_index == $past(group_index) + 2'd1))
    else $error("group order broken");

  // Last flag marks the translation group
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> last_group == (group_index == GRP_XLATE))
    else $error("last flag wrong");

  // Fourth entry is one on the translation group, zero elsewhere
  a_fourth: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> elem_fourth == ((group_index == GRP_XLATE) ? ONE_Q : '0))
    else $error("fourth entry wrong");

  // A zero-width wall is degenerate
  a_degen: assert property (@(posedge clk) disable iff (rst)
    out_valid && (wall_width == '0) |-> degenerate)
    else $error("zero width not flagged");

endmodule

bind wall_corners_to_view_matrix wcvm_checker u_wcvm_checker (
  .clk(clk),
  .rst(rst),
  .out_valid(matrix.valid),
  .out_ready(matrix.ready),
  .group_index(matrix.group_index),
  .elem_fourth(matrix.elem_fourth),
  .wall_width(matrix.wall_width),
  .degenerate(matrix.degenerate),
  .last_group(matrix.last_group)
);

[tb/wcvm_view_checker.sv]
// Checker for the wall-corners-to-view-matrix block: watches both channels,
// computes the expected matrix groups per accepted wall and compares them.
// Depends on wcvm_pkg.
module wcvm_view_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] in_coord [9],
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_group,
  input  logic [31:0] out_first,
  input  logic [31:0] out_second,
  input  logic [31:0] out_third,
  input  logic [31:0] out_fourth,
  input  logic [31:0] out_width,
  input  logic [31:0] out_height,
  input  logic        out_degen,
  input  logic        out_last,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import wcvm_pkg::*;

  typedef struct packed {
    logic [1:0]  group;
    logic [31:0] first;
    logic [31:0] second;
    logic [31:0] third;
    logic [31:0] fourth;
    logic [31:0] width;
    logic [31:0] height;
    logic        degen;
    logic        last;
  } view_group_t;

  view_group_t group_queue[$];

  // Floor square root of an unsigned value up to 128 bits
  function automatic logic [63:0] floor_sqrt(input logic [127:0] n);
    logic [63:0] res;
    logic [63:0] cand;
    res = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = res | (64'd1 << b);
      if ({64'd0, cand} * {64'd0, cand} <= n) res = cand;
    end
    return res;
  endfunction

  // Normalize a vector to Q.F, rounding half away from zero; return length
  function automatic logic [63:0] normalize(input longint c [3], output longint unit_out [3]);
    logic [127:0] sum;
    logic [63:0]  len;
    logic [127:0] mag;
    logic [127:0] q;
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      mag = (c[i] < 0) ? 128'(-c[i]) : 128'(c[i]);
      sum += mag * mag;
    end
    len = floor_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      mag = (c[i] < 0) ? 128'(-c[i]) : 128'(c[i]);
      if (len == 0) begin
        unit_out[i] = 0;
      end else begin
        q = ((mag << (FRAC_BITS + 1)) / len + 1) >> 1;
        unit_out[i] = (c[i] < 0) ? -longint'(q) : longint'(q);
      end
    end
    return len;
  endfunction

  // Saturate a signed wide value to 32-bit signed
  function automatic logic [31:0] clamp_signed(input logic signed [127:0] x);
    if (x > 128'sd2147483647) return SAT_MAX;
    if (x < -128'sd2147483648) return SAT_MIN;
    return x[31:0];
  endfunction

  // Build the four expected groups for one wall
  task automatic predict_view(input logic [31:0] raw [9]);
    longint bl [3], br [3], tl [3], u [3], v [3], csum [3], wc [3];
    longint uh [3], vh [3], wh [3];
    logic [63:0] ulen, vlen, wlen;
    logic [31:0] tr [3];
    logic signed [127:0] dot;
    logic [31:0] width, height;
    logic degen;
    view_group_t g;
    for (int i = 0; i < 3; i++) begin
      bl[i] = longint'($signed(raw[i]));
      br[i] = longint'($signed(raw[3 + i]));
      tl[i] = longint'($signed(raw[6 + i]));
      u[i] = br[i] - bl[i];
      v[i] = tl[i] - bl[i];
      csum[i] = br[i] + tl[i];
    end
    ulen = normalize(u, uh);
    vlen = normalize(v, vh);
    wc[0] = uh[1] * vh[2] - uh[2] * vh[1];
    wc[1] = uh[2] * vh[0] - uh[0] * vh[2];
    wc[2] = uh[0] * vh[1] - uh[1] * vh[0];
    wlen = normalize(wc, wh);
    width = (ulen > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : ulen[31:0];
    height = (vlen > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : vlen[31:0];
    degen = (ulen == 0) || (vlen == 0) || (wlen == 0);
    for (int k = 0; k < 3; k++) begin
      dot = '0;
      for (int i = 0; i < 3; i++) begin
        case (k)
          0: dot += 128'(uh[i]) * 128'(csum[i]);
          1: dot += 128'(vh[i]) * 128'(csum[i]);
          default: dot += 128'(wh[i]) * 128'(csum[i]);
        endcase
      end
      dot = -dot + (128'sd1 <<< FRAC_BITS);
      tr[k] = clamp_signed(dot >>> (FRAC_BITS + 1));
    end
    for (int k = 0; k < 4; k++) begin
      g.group = k[1:0];
      g.width = width;
      g.height = height;
      g.degen = degen;
      g.last = (k[1:0] == GRP_XLATE);
      if (k < 3) begin
        g.first = 32'(uh[k]);
        g.second = 32'(vh[k]);
        g.third = 32'(wh[k]);
        g.fourth = '0;
      end else begin
        g.first = tr[0];
        g.second = tr[1];
        g.third = tr[2];
        g.fourth = ONE_Q;
      end
      group_queue.push_back(g);
    end
  endtask

  // Record one mismatch, reporting only the first few
  task automatic report_mismatch(input string what, input view_group_t exp_g,
                                 input view_group_t act_g);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch %s: expected %h actual %h", what, exp_g, act_g);
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  // Predict on input handshakes, compare on output handshakes
  always @(posedge clk) begin
    view_group_t act_g;
    view_group_t exp_g;
    if (!rst) begin
      if (in_valid && in_ready) predict_view(in_coord);
      if (out_valid && out_ready) begin
        act_g = '{out_group, out_first, out_second, out_third, out_fourth,
                  out_width, out_height, out_degen, out_last};
        if (group_queue.size() == 0) begin
          report_mismatch("unexpected group", '0, act_g);
        end else begin
          exp_g = group_queue.pop_front();
          if (exp_g.group != act_g.group) report_mismatch("group_index", exp_g, act_g);
          if (exp_g.first != act_g.first) report_mismatch("elem_first", exp_g, act_g);
          if (exp_g.second != act_g.second) report_mismatch("elem_second", exp_g, act_g);
          if (exp_g.third != act_g.third) report_mismatch("elem_third", exp_g, act_g);
          if (exp_g.fourth != act_g.fourth) report_mismatch("elem_fourth", exp_g, act_g);
          if (exp_g.width != act_g.width) report_mismatch("wall_width", exp_g, act_g);
          if (exp_g.height != act_g.height) report_mismatch("wall_height", exp_g, act_g);
          if (exp_g.degen != act_g.degen) report_mismatch("degenerate", exp_g, act_g);
          if (exp_g.last != act_g.last) report_mismatch("last_group", exp_g, act_g);
        end
      end
    end
    pending = group_queue.size();
  end
endmodule

[tb/wall_corners_to_view_matrix_test.sv]
// Testbench top for the wall-corners-to-view-matrix block: drives walls,
// stalls the output at random and gives the verdict.
// Depends on wcvm_pkg, wcvm_in_if, wcvm_out_if, wall_corners_to_view_matrix and wcvm_view_checker.
module wall_corners_to_view_matrix_test;
  timeunit 1ns;
  timeprecision 1ps;
  import wcvm_pkg::*;

  localparam int WALL_COUNT = 450;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic idle_free = 1'b0;
  logic stim_done = 1'b0;
  int   fail_count;
  int   pending;
  logic [31:0] in_coord [9];

  wcvm_in_if  wall ();
  wcvm_out_if matrix ();

  wall_corners_to_view_matrix uut (.clk(clk), .rst(rst), .wall(wall), .matrix(matrix));

  assign in_coord = '{wall.bottom_left_x, wall.bottom_left_y, wall.bottom_left_z,
                      wall.bottom_right_x, wall.bottom_right_y, wall.bottom_right_z,
                      wall.top_left_x, wall.top_left_y, wall.top_left_z};

  wcvm_view_checker view_check (
    .clk(clk), .rst(rst),
    .in_valid(wall.valid), .in_ready(wall.ready), .in_coord(in_coord),
    .out_valid(matrix.valid), .out_ready(matrix.ready),
    .out_group(matrix.group_index), .out_first(matrix.elem_first),
    .out_second(matrix.elem_second), .out_third(matrix.elem_third),
    .out_fourth(matrix.elem_fourth), .out_width(matrix.wall_width),
    .out_height(matrix.wall_height), .out_degen(matrix.degenerate),
    .out_last(matrix.last_group), .fail_count(fail_count), .pending(pending)
  );

  always #2 clk = ~clk;

  // Pick a coordinate: extremes, small values, mid-range values or full random
  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($signed($urandom_range(0, 2048)) - 1024);
      3, 4: return $urandom;
      default: return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
    endcase
  endfunction

  // Present one wall and hold it until accepted
  task automatic send_wall(input logic [31:0] c [9]);
    int gap;
    if (!idle_free && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      wall.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    wall.valid <= 1'b1;
    {wall.bottom_left_x, wall.bottom_left_y, wall.bottom_left_z} <= {c[0], c[1], c[2]};
    {wall.bottom_right_x, wall.bottom_right_y, wall.bottom_right_z} <= {c[3], c[4], c[5]};
    {wall.top_left_x, wall.top_left_y, wall.top_left_z} <= {c[6], c[7], c[8]};
    @(posedge clk);
    while (!wall.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stall the output in random bursts
  initial begin
    int burst;
    matrix.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (!idle_free && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 9);
        matrix.ready <= 1'b0;
        repeat (burst) @(negedge clk);
      end
      matrix.ready <= 1'b1;
      @(negedge clk);
    end
  end

  // Stimulus: directed corners, then random walls, then the verdict
  initial begin
    logic [31:0] c [9];
    wall.valid = 1'b0;
    {wall.bottom_left_x, wall.bottom_left_y, wall.bottom_left_z} = '0;
    {wall.bottom_right_x, wall.bottom_right_y, wall.bottom_right_z} = '0;
    {wall.top_left_x, wall.top_left_y, wall.top_left_z} = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // unit wall, all zero, zero u, zero v, collinear edges
    send_wall('{0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0});
    send_wall('{0, 0, 0, 0, 0, 0, 0, 0, 0});
    send_wall('{5, 6, 7, 5, 6, 7, 32'h30000, 1, 2});
    send_wall('{5, 6, 7, 32'h30000, 1, 2, 5, 6, 7});
    send_wall('{0, 0, 0, 32'h20000, 32'h20000, 0, 32'h40000, 32'h40000, 0});
    // extremes of every coordinate, then edges of one LSB
    send_wall('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h7FFF_FFFF});
    send_wall('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h7FFF_FFFF});
    send_wall('{32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0, 32'h8000_0000,
                32'h7FFF_FFFF, 0});
    send_wall('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF});
    send_wall('{0, 0, 0, 1, 0, 0, 0, 1, 0});
    for (int n = 0; n < 10; n++) begin
      foreach (c[i]) c[i] = pick_coord();
      send_wall(c);
    end
    for (int n = 0; n < WALL_COUNT; n++) begin
      if (n == WALL_COUNT - 60) idle_free = 1'b1;
      foreach (c[i]) c[i] = pick_coord();
      // sometimes share a corner coordinate so edges lie on an axis
      if ($urandom_range(0, 5) == 0) c[$urandom_range(3, 8)] = c[$urandom_range(0, 2)];
      send_wall(c);
    end
    wall.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Bound the run
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end
endmodule
